// File: design/mrq_pkg.sv
package mrq_pkg;

   localparam int QS_W   = 5;
   localparam int REQ_W  = 2;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int CNT_W  = 32;
   localparam int ST_W   = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_ENQ  = 2'd0,
      REQ_DEQ  = 2'd1,
      REQ_CLR  = 2'd2,
      REQ_NONE = 2'd3
   } req_code_type;

   // Also serves as the pending drop reason, where ST_OK means no drop.
   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_LONG  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic byte_we;
      logic byte_re;
      logic len_we;
      logic len_re;
   } mem_ctl_type;

endpackage

// File: design/mrq_req_if.sv
interface mrq_req_if;
   import mrq_pkg::*;

   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, req_type, data_byte, last_byte, input ready);
   modport sink   (input valid, req_type, data_byte, last_byte, output ready);

endinterface

// File: design/mrq_rsp_if.sv
interface mrq_rsp_if;
   import mrq_pkg::*;

   logic              valid;
   logic              ready;
   logic [ST_W-1:0]   status;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;
   logic [LEN_W-1:0]  msg_length;
   logic [CNT_W-1:0]  full_count;
   logic [CNT_W-1:0]  empty_count;
   logic [CNT_W-1:0]  accepted_count;
   logic [CNT_W-1:0]  delivered_count;

   modport source (output valid, status, out_byte, out_last, msg_length, full_count,
                   empty_count, accepted_count, delivered_count, input ready);
   modport sink   (input valid, status, out_byte, out_last, msg_length, full_count,
                   empty_count, accepted_count, delivered_count, output ready);

endinterface

// File: design/mrq_store.sv
module mrq_store #(
   parameter int SLOT_COUNT = 16,
   parameter int MSG_BYTES  = 64,
   localparam int SLOT_W = $clog2(SLOT_COUNT),
   localparam int OFF_W  = $clog2(MSG_BYTES + 1),
   localparam int ADDR_W = $clog2(SLOT_COUNT * MSG_BYTES)
) (
   input  logic                        clock,
   input  mrq_pkg::mem_ctl_type        mem_ctl,
   input  logic [ADDR_W-1:0]           byte_waddr,
   input  logic [mrq_pkg::BYTE_W-1:0]  byte_wdata,
   input  logic [ADDR_W-1:0]           byte_raddr,
   output logic [mrq_pkg::BYTE_W-1:0]  byte_rdata,
   input  logic [SLOT_W-1:0]           len_wslot,
   input  logic [OFF_W-1:0]            len_wdata,
   input  logic [SLOT_W-1:0]           len_rslot,
   output logic [OFF_W-1:0]            len_rdata
);
   import mrq_pkg::*;

   logic [BYTE_W-1:0] byte_mem [SLOT_COUNT*MSG_BYTES];
   logic [OFF_W-1:0]  len_mem  [SLOT_COUNT];
   logic [BYTE_W-1:0] byte_rdata_ff;
   logic [OFF_W-1:0]  len_rdata_ff;

   // Read data holds between reads, so the controller may wait on it.
   always_ff @(posedge clock) begin
      if (mem_ctl.byte_we) begin
         byte_mem[byte_waddr] <= byte_wdata;
      end
      if (mem_ctl.byte_re) begin
         byte_rdata_ff <= byte_mem[byte_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.len_we) begin
         len_mem[len_wslot] <= len_wdata;
      end
      if (mem_ctl.len_re) begin
         len_rdata_ff <= len_mem[len_rslot];
      end
   end

   assign byte_rdata = byte_rdata_ff;
   assign len_rdata  = len_rdata_ff;

endmodule

// File: design/mrq_ctrl.sv
module mrq_ctrl #(
   parameter int SLOT_COUNT = 16,
   parameter int MSG_BYTES  = 64,
   localparam int SLOT_W = $clog2(SLOT_COUNT),
   localparam int OFF_W  = $clog2(MSG_BYTES + 1),
   localparam int ADDR_W = $clog2(SLOT_COUNT * MSG_BYTES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mrq_pkg::QS_W-1:0]    qsize,
   input  logic                        flush,
   mrq_req_if.sink                     req_ch,
   mrq_rsp_if.source                   rsp_ch,
   output mrq_pkg::mem_ctl_type        mem_ctl,
   output logic [ADDR_W-1:0]           byte_waddr,
   output logic [mrq_pkg::BYTE_W-1:0]  byte_wdata,
   output logic [ADDR_W-1:0]           byte_raddr,
   input  logic [mrq_pkg::BYTE_W-1:0]  byte_rdata,
   output logic [SLOT_W-1:0]           len_wslot,
   output logic [OFF_W-1:0]            len_wdata,
   output logic [SLOT_W-1:0]           len_rslot,
   input  logic [OFF_W-1:0]            len_rdata
);
   import mrq_pkg::*;

   localparam int NXT_W = (SLOT_W + 1 > QS_W) ? SLOT_W + 1 : QS_W;

   typedef enum logic [1:0] {S_IDLE, S_LEN, S_STREAM} state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in, rd_slot_ff, rd_slot_in;
   logic [OFF_W-1:0]  off_ff, off_in, idx_ff, idx_in, cur_len_ff, cur_len_in;
   status_type        drop_ff, drop_in;
   logic [CNT_W-1:0]  full_cnt_ff, full_cnt_in, empty_cnt_ff, empty_cnt_in;
   logic [CNT_W-1:0]  acc_cnt_ff, acc_cnt_in, del_cnt_ff, del_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic              olast_ff, olast_in;
   logic [LEN_W-1:0]  olen_ff, olen_in;

   logic              out_free;
   logic              accept;
   status_type        drop_n;
   logic [OFF_W-1:0]  off_n;
   logic [OFF_W-1:0]  len_c;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] cur,
                                                  input logic [QS_W-1:0] size);
      logic [NXT_W-1:0]  nxt;
      logic [SLOT_W-1:0] res;
      nxt = NXT_W'(cur) + NXT_W'(1);
      if (nxt >= NXT_W'(size)) begin
         res = '0;
      end else begin
         res = nxt[SLOT_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [OFF_W-1:0] off);
      return ADDR_W'(slot) * ADDR_W'(MSG_BYTES) + ADDR_W'(off);
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && (state_ff == S_IDLE) && out_free;

   // A length read past the message size can only come from a corrupt entry.
   assign len_c = (32'(len_rdata) > MSG_BYTES) ? OFF_W'(MSG_BYTES) : len_rdata;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rd_slot_in   = rd_slot_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      cur_len_in   = cur_len_ff;
      drop_in      = drop_ff;
      full_cnt_in  = full_cnt_ff;
      empty_cnt_in = empty_cnt_ff;
      acc_cnt_in   = acc_cnt_ff;
      del_cnt_in   = del_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      obyte_in     = obyte_ff;
      olast_in     = olast_ff;
      olen_in      = olen_ff;
      drop_n       = drop_ff;
      off_n        = off_ff;
      mem_ctl      = '0;
      byte_waddr   = byte_addr(tail_ff, off_ff);
      byte_wdata   = req_ch.data_byte;
      byte_raddr   = byte_addr(rd_slot_ff, '0);
      len_wslot    = tail_ff;
      len_wdata    = off_ff;
      len_rslot    = head_ff;

      priority if (flush) begin
         head_in  = '0;
         tail_in  = '0;
         off_in   = '0;
         drop_in  = ST_OK;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_code_type'(req_ch.req_type))
                     REQ_ENQ: begin
                        if (drop_ff == ST_OK) begin
                           priority if (off_ff == '0 &&
                                        next_slot(tail_ff, qsize) == head_ff) begin
                              drop_n      = ST_FULL;
                              full_cnt_in = full_cnt_ff + CNT_W'(1);
                           end else if (32'(off_ff) >= MSG_BYTES) begin
                              drop_n      = ST_LONG;
                              full_cnt_in = full_cnt_ff + CNT_W'(1);
                           end else begin
                              mem_ctl.byte_we = 1'b1;
                              off_n           = off_ff + OFF_W'(1);
                           end
                        end
                        if (req_ch.last_byte) begin
                           rsp_valid_in = 1'b1;
                           obyte_in     = '0;
                           olast_in     = 1'b1;
                           olen_in      = '0;
                           off_in       = '0;
                           drop_in      = ST_OK;
                           if (drop_n != ST_OK) begin
                              status_in = drop_n;
                           end else begin
                              status_in      = ST_OK;
                              mem_ctl.len_we = 1'b1;
                              len_wdata      = off_n;
                              tail_in        = next_slot(tail_ff, qsize);
                              acc_cnt_in     = acc_cnt_ff + CNT_W'(1);
                           end
                        end else begin
                           off_in  = off_n;
                           drop_in = drop_n;
                        end
                     end
                     REQ_DEQ: begin
                        if (head_ff == tail_ff) begin
                           empty_cnt_in = empty_cnt_ff + CNT_W'(1);
                           rsp_valid_in = 1'b1;
                           status_in    = ST_EMPTY;
                           obyte_in     = '0;
                           olast_in     = 1'b1;
                           olen_in      = '0;
                        end else begin
                           mem_ctl.len_re = 1'b1;
                           rd_slot_in     = head_ff;
                           head_in        = next_slot(head_ff, qsize);
                           del_cnt_in     = del_cnt_ff + CNT_W'(1);
                           state_in       = S_LEN;
                        end
                     end
                     REQ_CLR: begin
                        head_in      = '0;
                        tail_in      = '0;
                        off_in       = '0;
                        drop_in      = ST_OK;
                        rsp_valid_in = 1'b1;
                        status_in    = ST_OK;
                        obyte_in     = '0;
                        olast_in     = 1'b1;
                        olen_in      = '0;
                     end
                     REQ_NONE: begin
                     end
                  endcase
               end
            end
            S_LEN: begin
               if (len_c == '0) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_OK;
                     obyte_in     = '0;
                     olast_in     = 1'b1;
                     olen_in      = '0;
                     state_in     = S_IDLE;
                  end
               end else begin
                  mem_ctl.byte_re = 1'b1;
                  byte_raddr      = byte_addr(rd_slot_ff, '0);
                  cur_len_in      = len_c;
                  idx_in          = '0;
                  state_in        = S_STREAM;
               end
            end
            S_STREAM: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_OK;
                  obyte_in     = byte_rdata;
                  olast_in     = (idx_ff + OFF_W'(1) == cur_len_ff);
                  olen_in      = LEN_W'(cur_len_ff);
                  if (idx_ff + OFF_W'(1) == cur_len_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     mem_ctl.byte_re = 1'b1;
                     byte_raddr      = byte_addr(rd_slot_ff, idx_ff + OFF_W'(1));
                     idx_in          = idx_ff + OFF_W'(1);
                  end
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= rd_slot_in;
      idx_ff     <= idx_in;
      cur_len_ff <= cur_len_in;
      status_ff  <= status_in;
      obyte_ff   <= obyte_in;
      olast_ff   <= olast_in;
      olen_ff    <= olen_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         off_ff       <= '0;
         drop_ff      <= ST_OK;
         full_cnt_ff  <= '0;
         empty_cnt_ff <= '0;
         acc_cnt_ff   <= '0;
         del_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         off_ff       <= off_in;
         drop_ff      <= drop_in;
         full_cnt_ff  <= full_cnt_in;
         empty_cnt_ff <= empty_cnt_in;
         acc_cnt_ff   <= acc_cnt_in;
         del_cnt_ff   <= del_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ch.ready           = (state_ff == S_IDLE) && out_free;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.out_byte        = obyte_ff;
   assign rsp_ch.out_last        = olast_ff;
   assign rsp_ch.msg_length      = olen_ff;
   // No item is taken while a result waits, so the live counters match it.
   assign rsp_ch.full_count      = full_cnt_ff;
   assign rsp_ch.empty_count     = empty_cnt_ff;
   assign rsp_ch.accepted_count  = acc_cnt_ff;
   assign rsp_ch.delivered_count = del_cnt_ff;

endmodule

// File: design/message_ring_queue_unit.sv
// Ring queue of variable-length byte messages.
// The request channel carries one item per cycle while its ready is high: an
// enqueue byte (with a last mark on the final byte), a dequeue request or a
// clear. The response channel returns one item for each final enqueue byte
// (its status), one item per byte of a dequeued message (with its length and a
// last mark), or one status item for an empty dequeue and for a clear.
// Non-final enqueue bytes return nothing. The csr port writes the number of
// slots in use; the value is saturated into the range two to SLOT_COUNT and
// the queue is emptied, counters being kept. A dequeue first reads the slot
// length from the length memory, then the first byte from the message memory,
// then one byte per cycle while the receiver takes them; no new request is
// taken until the last byte is in the output register. Results leave through a
// single output register. When the receiver stalls the register holds its
// item, streaming pauses and the request ready stays low until the item is
// taken. Reset empties the queue, clears the four counters and sets the slot
// count to sixteen, or SLOT_COUNT if smaller. The memories are not cleared:
// only entries that have been written are ever read.
module message_ring_queue_unit #(
   parameter int SLOT_COUNT = 16,
   parameter int MSG_BYTES  = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [mrq_pkg::QS_W-1:0]  csr_wr_data,
   mrq_req_if.sink                   req_ch,
   mrq_rsp_if.source                 rsp_ch
);
   import mrq_pkg::*;

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int OFF_W  = $clog2(MSG_BYTES + 1);
   localparam int ADDR_W = $clog2(SLOT_COUNT * MSG_BYTES);
   localparam logic [QS_W-1:0] QSIZE_RST = QS_W'((SLOT_COUNT < 16) ? SLOT_COUNT : 16);

   logic [QS_W-1:0]   qsize_ff, qsize_in;
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] byte_waddr, byte_raddr;
   logic [BYTE_W-1:0] byte_wdata, byte_rdata;
   logic [SLOT_W-1:0] len_wslot, len_rslot;
   logic [OFF_W-1:0]  len_wdata, len_rdata;

   // The slot count register saturates what is written into the legal range.
   always_comb begin
      qsize_in = qsize_ff;
      if (csr_wr_en) begin
         priority if (csr_wr_data < QS_W'(2)) begin
            qsize_in = QS_W'(2);
         end else if (32'(csr_wr_data) > SLOT_COUNT) begin
            qsize_in = QS_W'(SLOT_COUNT);
         end else begin
            qsize_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qsize_ff <= QSIZE_RST;
      end else begin
         qsize_ff <= qsize_in;
      end
   end

   // A register write also empties the queue, in the same cycle.
   mrq_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .MSG_BYTES  (MSG_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .qsize      (qsize_ff),
      .flush      (csr_wr_en),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .mem_ctl    (mem_ctl),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata),
      .len_wslot  (len_wslot),
      .len_wdata  (len_wdata),
      .len_rslot  (len_rslot),
      .len_rdata  (len_rdata)
   );

   // Reads and writes of the same entry never fall in the same cycle: a length
   // is written by a final enqueue byte and read at the earliest by the next
   // item, and message bytes are only read while no item is being taken.
   mrq_store #(
      .SLOT_COUNT (SLOT_COUNT),
      .MSG_BYTES  (MSG_BYTES)
   ) u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata),
      .len_wslot  (len_wslot),
      .len_wdata  (len_wdata),
      .len_rslot  (len_rslot),
      .len_rdata  (len_rdata)
   );

   // The counters are shown live, so they must not move under a waiting item.
   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         $stable(rsp_ch.full_count) && $stable(rsp_ch.empty_count) &&
         $stable(rsp_ch.accepted_count) && $stable(rsp_ch.delivered_count))
      else $error("counters changed while a result item was waiting");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |-> !rsp_ch.valid || rsp_ch.ready)
      else $error("request item taken while the output register was blocked");

   a_qsize_range: assert property (@(posedge clock) disable iff (reset)
      qsize_ff >= QS_W'(2) && 32'(qsize_ff) <= SLOT_COUNT)
      else $error("slot count outside its legal range");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_EMPTY |->
         rsp_ch.out_last && rsp_ch.msg_length == '0 && rsp_ch.out_byte == '0)
      else $error("empty status item carries data");

endmodule
